@@ design/abd_pkg.sv @@
// anchor box decode package: item and config types, fixed-point constants
// and the power-of-two fraction series used to build the exp table
// no dependencies
package abd_pkg;

    localparam int MAX_GRID_SIDE_DEF  = 1024;
    localparam int EXP_TABLE_SIZE_DEF = 256;

    localparam longint unsigned LN2_Q32   = 64'd2977044472;
    localparam logic [30:0]     LOG2E_Q30 = 31'd1549082005;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STRIDE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_HEIGHT = 3'd4;

    localparam logic [8:0]  STRIDE_RESET = 9'd8;
    localparam logic [15:0] SCALE_RESET  = 16'd16384;

    // exponent clamp is +-16 in Q.16, offset so the biased value is unsigned
    localparam logic signed [23:0] EXP_LIM_LO = -24'sd1048576;
    localparam logic signed [23:0] EXP_LIM_HI = 24'sd1048575;
    localparam logic [4:0]         SHIFT_ZERO = 5'd28;

    localparam logic signed [33:0] COORD_MAX = 34'sd524287;
    localparam logic signed [33:0] COORD_MIN = -34'sd524288;

    typedef struct packed {
        logic [9:0]          gx;
        logic [9:0]          gy;
        logic [10:0]         aw;
        logic [10:0]         ah;
        logic signed [15:0]  dx;
        logic signed [15:0]  dy;
        logic signed [15:0]  dw;
        logic signed [15:0]  dh;
    } abd_item_t;

    typedef struct packed {
        logic [8:0]  stride;
        logic [15:0] sx0;
        logic [15:0] sy0;
        logic [15:0] sw;
        logic [15:0] sh;
    } abd_cfg_t;

    // round(2^(x/ln2) * 65536) from a 12-term series, x in Q.32
    function automatic logic [16:0] frac_pow2(input longint unsigned x);
        longint unsigned term;
        longint unsigned sum;
        term = 64'd1 << 32;
        sum  = term;
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * x) >> 32;
            unique case (n)
                1:       term = term;
                2:       term = term / 2;
                3:       term = term / 3;
                4:       term = term / 4;
                5:       term = term / 5;
                6:       term = term / 6;
                7:       term = term / 7;
                8:       term = term / 8;
                9:       term = term / 9;
                10:      term = term / 10;
                11:      term = term / 11;
                default: term = term / 12;
            endcase
            sum = sum + term;
        end
        return 17'((sum + (64'd1 << 15)) >> 16);
    endfunction

endpackage

@@ design/abd_front.sv @@
// front end: input register, drops zero-size anchors, clamps grid indexes
// depends on abd_pkg
module abd_front #(
    parameter int MAX_GRID_SIDE = abd_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  abd_pkg::abd_item_t in_item,
    output logic              push,
    output abd_pkg::abd_item_t push_item,
    input  logic              q_full
);
    import abd_pkg::*;

    localparam logic [12:0] SIDE_MAX = 13'(MAX_GRID_SIDE - 1);

    logic      hold_valid_reg;
    logic      hold_valid_next;
    abd_item_t hold_reg;
    logic      keep;
    logic      leave;

    // an anchor with a zero side yields nothing and is dropped here
    assign keep     = (hold_reg.aw != '0) && (hold_reg.ah != '0);
    assign push     = hold_valid_reg && keep && !q_full;
    assign leave    = hold_valid_reg && (!keep || !q_full);
    assign in_ready = !hold_valid_reg || leave;

    // grid clamp to the feature-map side
    always_comb
    begin
        push_item = hold_reg;
        if ({3'b0, hold_reg.gx} > SIDE_MAX)
            push_item.gx = SIDE_MAX[9:0];
        if ({3'b0, hold_reg.gy} > SIDE_MAX)
            push_item.gy = SIDE_MAX[9:0];
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
            hold_valid_next = 1'b1;
        else if (leave)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_reg <= in_item;
    end

endmodule

@@ design/abd_queue.sv @@
// two-entry queue between front and back ends
// depends on abd_pkg
module abd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  abd_pkg::abd_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output abd_pkg::abd_item_t pop_item
);
    import abd_pkg::*;

    abd_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !q_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

@@ design/abd_back.sv @@
// back end: five-stage elastic pipeline computing corners, exp extents and
// saturation, with the output register as its last stage; depends on abd_pkg
module abd_back #(
    parameter int EXP_TABLE_SIZE = abd_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  abd_pkg::abd_cfg_t  cfg,
    input  logic               q_valid,
    input  abd_pkg::abd_item_t q_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] box_left,
    output logic signed [19:0] box_top,
    output logic signed [19:0] box_right,
    output logic signed [19:0] box_bottom,
    output logic               saturated
);
    import abd_pkg::*;

    localparam int IW = $clog2(EXP_TABLE_SIZE);

    // fraction table 2^(i/EXP_TABLE_SIZE) in Q.16
    logic [16:0] exp_rom [EXP_TABLE_SIZE];
    for (genvar i = 0; i < EXP_TABLE_SIZE; i++)
    begin : g_rom
        localparam longint unsigned X =
            (longint'(i) * LN2_Q32 + longint'(EXP_TABLE_SIZE / 2)) / EXP_TABLE_SIZE;
        assign exp_rom[i] = frac_pow2(X);
    end

    function automatic logic [20:0] clamp_coord(input logic signed [33:0] v);
        if (v > COORD_MAX)
            return {1'b1, COORD_MAX[19:0]};
        if (v < COORD_MIN)
            return {1'b1, COORD_MIN[19:0]};
        return {1'b0, v[19:0]};
    endfunction

    function automatic logic [31:0] scale_extent(input logic [27:0] m,
                                                 input logic [4:0] uhi);
        logic [4:0]  n;
        logic [28:0] half;
        logic [28:0] sum;
        n    = SHIFT_ZERO - uhi;
        half = 29'd1 << (n - 5'd1);
        sum  = {1'b0, m} + half;
        if (uhi >= SHIFT_ZERO)
            return {4'b0, m} << (uhi - SHIFT_ZERO);
        return {3'b0, sum >> n};
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    // stage 1 data
    logic signed [31:0] px_reg, py_reg, pw_reg, ph_reg;
    logic [18:0]        gsx_reg, gsy_reg;
    logic [10:0]        aw1_reg, ah1_reg;
    // stage 2 data
    logic signed [44:0] cx_reg, cy_reg;
    logic signed [63:0] ew_reg, eh_reg;
    logic signed [25:0] bx_reg, by_reg;
    logic [10:0]        aw2_reg, ah2_reg;
    // stage 3 data
    logic signed [26:0] x03_reg, y03_reg;
    logic [IW-1:0]      idxw_reg, idxh_reg;
    logic [4:0]         uhw3_reg, uhh3_reg;
    logic               sat3_reg;
    logic [10:0]        aw3_reg, ah3_reg;
    // stage 4 data
    logic signed [26:0] x04_reg, y04_reg;
    logic [27:0]        mw_reg, mh_reg;
    logic [4:0]         uhw4_reg, uhh4_reg;
    logic               sat4_reg;

    // stall chain, the output register is the last stage
    assign adv5 = !v5_reg || out_ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign pop  = q_valid && adv1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= q_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // stage 1: delta times coefficient, grid times stride
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            px_reg  <= 32'(q_item.dx) * $signed({16'b0, cfg.sx0});
            py_reg  <= 32'(q_item.dy) * $signed({16'b0, cfg.sy0});
            pw_reg  <= 32'(q_item.dw) * $signed({16'b0, cfg.sw});
            ph_reg  <= 32'(q_item.dh) * $signed({16'b0, cfg.sh});
            gsx_reg <= {9'b0, q_item.gx} * {10'b0, cfg.stride};
            gsy_reg <= {9'b0, q_item.gy} * {10'b0, cfg.stride};
            aw1_reg <= q_item.aw;
            ah1_reg <= q_item.ah;
        end
    end

    // stage 2: corner offset products, exponent products, anchor corner
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            cx_reg  <= 45'(px_reg) * $signed({33'b0, 12'({1'b0, aw1_reg} + 12'd1)});
            cy_reg  <= 45'(py_reg) * $signed({33'b0, 12'({1'b0, ah1_reg} + 12'd1)});
            ew_reg  <= 64'(pw_reg) * $signed({33'b0, LOG2E_Q30});
            eh_reg  <= 64'(ph_reg) * $signed({33'b0, LOG2E_Q30});
            bx_reg  <= $signed(26'({gsx_reg, 4'b0}) + 26'({cfg.stride, 3'b0})
                       - 26'({aw1_reg, 3'b0}));
            by_reg  <= $signed(26'({gsy_reg, 4'b0}) + 26'({cfg.stride, 3'b0})
                       - 26'({ah1_reg, 3'b0}));
            aw2_reg <= aw1_reg;
            ah2_reg <= ah1_reg;
        end
    end

    // stage 3: rounding, exponent clamp and split into shift and index
    logic signed [44:0] rx, ry;
    logic signed [63:0] rw, rh;
    logic signed [23:0] ew_c, eh_c;
    logic [20:0]        uw, uh;
    logic               satw, sath;
    logic [28:0]        iprodw, iprodh;

    always_comb
    begin
        rx   = (cx_reg + 45'sd2097152) >>> 22;
        ry   = (cy_reg + 45'sd2097152) >>> 22;
        rw   = (ew_reg + 64'sd549755813888) >>> 40;
        rh   = (eh_reg + 64'sd549755813888) >>> 40;
        ew_c = rw[23:0];
        eh_c = rh[23:0];
        satw = 1'b0;
        sath = 1'b0;
        if (ew_c < EXP_LIM_LO)
        begin
            ew_c = EXP_LIM_LO;
            satw = 1'b1;
        end
        else if (ew_c > EXP_LIM_HI)
        begin
            ew_c = EXP_LIM_HI;
            satw = 1'b1;
        end
        if (eh_c < EXP_LIM_LO)
        begin
            eh_c = EXP_LIM_LO;
            sath = 1'b1;
        end
        else if (eh_c > EXP_LIM_HI)
        begin
            eh_c = EXP_LIM_HI;
            sath = 1'b1;
        end
        uw = 21'(ew_c - EXP_LIM_LO);
        uh = 21'(eh_c - EXP_LIM_LO);
        iprodw = {13'b0, uw[15:0]} * 29'(EXP_TABLE_SIZE);
        iprodh = {13'b0, uh[15:0]} * 29'(EXP_TABLE_SIZE);
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            x03_reg  <= 27'(bx_reg) + 27'($signed(rx[22:0]));
            y03_reg  <= 27'(by_reg) + 27'($signed(ry[22:0]));
            idxw_reg <= iprodw[16 +: IW];
            idxh_reg <= iprodh[16 +: IW];
            uhw3_reg <= uw[20:16];
            uhh3_reg <= uh[20:16];
            sat3_reg <= satw | sath;
            aw3_reg  <= aw2_reg;
            ah3_reg  <= ah2_reg;
        end
    end

    // stage 4: table lookup and mantissa product
    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            mw_reg   <= {17'b0, aw3_reg} * {11'b0, exp_rom[idxw_reg]};
            mh_reg   <= {17'b0, ah3_reg} * {11'b0, exp_rom[idxh_reg]};
            x04_reg  <= x03_reg;
            y04_reg  <= y03_reg;
            uhw4_reg <= uhw3_reg;
            uhh4_reg <= uhh3_reg;
            sat4_reg <= sat3_reg;
        end
    end

    // stage 5: extent shift, far corners, coordinate clamp
    logic [31:0] extw, exth;
    logic [20:0] cl_l, cl_t, cl_r, cl_b;

    always_comb
    begin
        extw = scale_extent(mw_reg, uhw4_reg);
        exth = scale_extent(mh_reg, uhh4_reg);
        cl_l = clamp_coord(34'(x04_reg));
        cl_t = clamp_coord(34'(y04_reg));
        cl_r = clamp_coord(34'(x04_reg) + $signed({2'b0, extw}) - 34'sd16);
        cl_b = clamp_coord(34'(y04_reg) + $signed({2'b0, exth}) - 34'sd16);
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            box_left   <= cl_l[19:0];
            box_top    <= cl_t[19:0];
            box_right  <= cl_r[19:0];
            box_bottom <= cl_b[19:0];
            saturated  <= sat4_reg | cl_l[20] | cl_t[20] | cl_r[20] | cl_b[20];
        end
    end

    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n) pop |=> v1_reg)
        else $error("popped transaction lost at stage one");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(box_left) && $stable(saturated))
        else $error("output register changed under stall");
    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && v5_reg && !out_ready) |=> v4_reg)
        else $error("stage four dropped under stall");

endmodule

@@ design/anchor_box_decode.sv @@
// anchor box decode top level: config registers, front end, queue, back end
// depends on abd_pkg, abd_front, abd_queue, abd_back
//
// Decodes one anchor per transaction into a box in signed Q16.4 pixels. One
// transaction is accepted per clock unless the queue is full; a result reaches
// the outputs through the input register, the queue and the five-stage pipeline
// whose last stage is the output register. Anchors with a zero width or height
// give no result. The back-end pipeline takes one anchor per clock unless the
// output is stalled. Configuration writes are always taken; write them only
// while the block is empty.
module anchor_box_decode #(
    parameter int MAX_GRID_SIDE  = abd_pkg::MAX_GRID_SIDE_DEF,
    parameter int EXP_TABLE_SIZE = abd_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [abd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [9:0]                      grid_x,
    input  logic [9:0]                      grid_y,
    input  logic [10:0]                     anchor_width,
    input  logic [10:0]                     anchor_height,
    input  logic signed [15:0]              delta_x0,
    input  logic signed [15:0]              delta_y0,
    input  logic signed [15:0]              delta_width,
    input  logic signed [15:0]              delta_height,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [19:0]              box_left,
    output logic signed [19:0]              box_top,
    output logic signed [19:0]              box_right,
    output logic signed [19:0]              box_bottom,
    output logic                            saturated
);
    import abd_pkg::*;

    abd_cfg_t  cfg_reg;
    abd_item_t in_item;
    abd_item_t push_item;
    abd_item_t pop_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_valid;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stride <= STRIDE_RESET;
            cfg_reg.sx0    <= SCALE_RESET;
            cfg_reg.sy0    <= SCALE_RESET;
            cfg_reg.sw     <= SCALE_RESET;
            cfg_reg.sh     <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRID_STRIDE:  cfg_reg.stride <= cfg_data[8:0];
                CFG_SCALE_X0:     cfg_reg.sx0    <= cfg_data;
                CFG_SCALE_Y0:     cfg_reg.sy0    <= cfg_data;
                CFG_SCALE_WIDTH:  cfg_reg.sw     <= cfg_data;
                CFG_SCALE_HEIGHT: cfg_reg.sh     <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_item = '{gx: grid_x, gy: grid_y, aw: anchor_width, ah: anchor_height,
                       dx: delta_x0, dy: delta_y0, dw: delta_width, dh: delta_height};

    abd_front #(.MAX_GRID_SIDE(MAX_GRID_SIDE)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    abd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    abd_back #(.EXP_TABLE_SIZE(EXP_TABLE_SIZE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_right  (box_right),
        .box_bottom (box_bottom),
        .saturated  (saturated)
    );

endmodule

@@ dv/tb.sv @@
// anchor box decode testbench: a bit-exact box predictor, a bursty item driver,
// a stalling result monitor and phased register settings
// depends on abd_pkg and anchor_box_decode
`timescale 1ns / 1ps

module tb;
    import abd_pkg::*;

    localparam int  GRID_SIDE   = 1024;
    localparam int  TAB_SIZE    = 256;
    localparam int  EXP_SPAN    = 16;
    localparam int  DRAIN_WAIT  = 20;
    localparam int  CYCLE_LIMIT = 300000;
    localparam int  PHASES      = 6;
    localparam int  PER_PHASE   = 142;
    localparam longint LN2_FIX    = 64'd2977044472;
    localparam longint LOG2E_FIX  = 64'd1549082005;
    localparam longint COORD_HI   = 524287;
    localparam longint COORD_LO   = -524288;

    typedef struct packed {
        logic signed [19:0] left;
        logic signed [19:0] top;
        logic signed [19:0] right;
        logic signed [19:0] bottom;
        logic               sat;
    } box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [9:0] grid_x = '0;
    logic [9:0] grid_y = '0;
    logic [10:0] anchor_width = '0;
    logic [10:0] anchor_height = '0;
    logic signed [15:0] delta_x0 = '0;
    logic signed [15:0] delta_y0 = '0;
    logic signed [15:0] delta_width = '0;
    logic signed [15:0] delta_height = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [19:0] box_left;
    logic signed [19:0] box_top;
    logic signed [19:0] box_right;
    logic signed [19:0] box_bottom;
    logic saturated;

    abd_item_t pending_anchors[$];
    box_t      expected_boxes[$];
    abd_cfg_t  shadow_cfg;
    longint    pow2_frac[TAB_SIZE];
    int        error_count = 0;
    int        cycle_count = 0;
    int        stall_pct = 0;
    int        max_gap = 0;
    bit        hold_req = 1'b0;

    anchor_box_decode dut (.*);

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // round half up shift of a signed value
    function automatic longint rshift_round(longint v, int n);
        if (n == 0)
            return v;
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_coord(longint v, ref bit sat);
        if (v > COORD_HI)
        begin
            sat = 1'b1;
            return COORD_HI;
        end
        if (v < COORD_LO)
        begin
            sat = 1'b1;
            return COORD_LO;
        end
        return v;
    endfunction

    // box extent in Q.4: size * 2^(delta*scale*log2e)
    function automatic longint box_extent(longint size, longint d, longint s, ref bit sat);
        longint lim;
        longint e;
        longint u;
        longint k;
        longint sh;
        longint m;
        int     idx;
        lim = longint'(EXP_SPAN) << 16;
        e = rshift_round(d * s * LOG2E_FIX, 40);
        if (e < -lim)
        begin
            e = -lim;
            sat = 1'b1;
        end
        if (e > lim - 1)
        begin
            e = lim - 1;
            sat = 1'b1;
        end
        u = e + lim;
        k = (u >>> 16) - EXP_SPAN;
        idx = int'(((u & 64'hFFFF) * TAB_SIZE) >> 16);
        m = size * pow2_frac[idx];
        sh = k - 12;
        if (sh >= 0)
            return m << sh;
        return rshift_round(m, int'(-sh));
    endfunction

    function automatic longint box_corner(longint g, longint size, longint d, longint s);
        longint stride;
        stride = longint'(shadow_cfg.stride);
        return g * stride * 16 + stride * 8 - size * 8 + rshift_round(d * s * (size + 1), 22);
    endfunction

    // decoded box for one anchor, zero when the anchor has no area
    function automatic bit decode_box(abd_item_t a, output box_t b);
        longint gx;
        longint gy;
        longint x0;
        longint y0;
        longint w;
        longint h;
        bit     sat;
        sat = 1'b0;
        b = '0;
        if (a.aw == 0 || a.ah == 0)
            return 1'b0;
        gx = (a.gx > GRID_SIDE - 1) ? GRID_SIDE - 1 : a.gx;
        gy = (a.gy > GRID_SIDE - 1) ? GRID_SIDE - 1 : a.gy;
        x0 = box_corner(gx, a.aw, a.dx, shadow_cfg.sx0);
        y0 = box_corner(gy, a.ah, a.dy, shadow_cfg.sy0);
        w = box_extent(a.aw, a.dw, shadow_cfg.sw, sat);
        h = box_extent(a.ah, a.dh, shadow_cfg.sh, sat);
        b.left   = 20'(clamp_coord(x0, sat));
        b.top    = 20'(clamp_coord(y0, sat));
        b.right  = 20'(clamp_coord(x0 + w - 16, sat));
        b.bottom = 20'(clamp_coord(y0 + h - 16, sat));
        b.sat    = sat;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // random delta, mostly moderate so boxes stay in range
    function automatic logic [15:0] rand_delta();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 4096) - 2048);
            default: return 16'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    function automatic abd_item_t rand_anchor();
        abd_item_t a;
        a.gx = 10'($urandom);
        a.gy = 10'($urandom);
        a.aw = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 128));
        a.ah = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 128));
        if ($urandom_range(0, 15) == 0)
            a.aw = '0;
        if ($urandom_range(0, 15) == 0)
            a.ah = '0;
        a.dx = rand_delta();
        a.dy = rand_delta();
        a.dw = rand_delta();
        a.dh = rand_delta();
        return a;
    endfunction

    function automatic abd_item_t mk_anchor(logic [9:0] gx, logic [9:0] gy,
                                            logic [10:0] aw, logic [10:0] ah,
                                            logic [15:0] dx, logic [15:0] dy,
                                            logic [15:0] dw, logic [15:0] dh);
        abd_item_t a;
        a.gx = gx;
        a.gy = gy;
        a.aw = aw;
        a.ah = ah;
        a.dx = dx;
        a.dy = dy;
        a.dw = dw;
        a.dh = dh;
        return a;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_anchors.size() != 0 || in_valid || expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // power-of-two fraction table in Q.16 from an integer series
    initial
    begin
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            x = (longint'(i) * LN2_FIX + TAB_SIZE / 2) / TAB_SIZE;
            term = 64'd1 << 32;
            sum = term;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x) >> 32) / n;
                sum += term;
            end
            pow2_frac[i] = longint'((sum + (64'd1 << 15)) >> 16);
        end
    end

    // item driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        abd_item_t a;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_gap);
            end
            if (gap_left > 0 || pending_anchors.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                a = pending_anchors.pop_front();
                burst_left--;
                grid_x        <= a.gx;
                grid_y        <= a.gy;
                anchor_width  <= a.aw;
                anchor_height <= a.ah;
                delta_x0      <= a.dx;
                delta_y0      <= a.dy;
                delta_width   <= a.dw;
                delta_height  <= a.dh;
                in_valid      <= 1'b1;
            end
        end
    end

    // receiver stalls, plus one long hold-off on request
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // accepted transactions: predict, track config, check results
    always @(posedge clk)
    begin
        abd_item_t a;
        box_t      b;
        box_t      want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_STRIDE:  shadow_cfg.stride = cfg_data[8:0];
                    CFG_SCALE_X0:     shadow_cfg.sx0 = cfg_data;
                    CFG_SCALE_Y0:     shadow_cfg.sy0 = cfg_data;
                    CFG_SCALE_WIDTH:  shadow_cfg.sw = cfg_data;
                    CFG_SCALE_HEIGHT: shadow_cfg.sh = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                a = mk_anchor(grid_x, grid_y, anchor_width, anchor_height,
                              delta_x0, delta_y0, delta_width, delta_height);
                if (decode_box(a, b))
                    expected_boxes.push_back(b);
            end
            if (out_valid && out_ready)
            begin
                if (expected_boxes.size() == 0)
                begin
                    $display("unexpected box transaction at cycle %0d", cycle_count);
                    error_count++;
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    if (box_left !== want.left)
                        report_mismatch("box_left", box_left, want.left);
                    if (box_top !== want.top)
                        report_mismatch("box_top", box_top, want.top);
                    if (box_right !== want.right)
                        report_mismatch("box_right", box_right, want.right);
                    if (box_bottom !== want.bottom)
                        report_mismatch("box_bottom", box_bottom, want.bottom);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("anchor_box_decode test failed");
            $finish;
        end
    end

    // reset, register settings per phase, stimulus
    initial
    begin
        shadow_cfg.stride = STRIDE_RESET;
        shadow_cfg.sx0 = SCALE_RESET;
        shadow_cfg.sy0 = SCALE_RESET;
        shadow_cfg.sw = SCALE_RESET;
        shadow_cfg.sh = SCALE_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed anchors under reset settings
        pending_anchors.push_back(mk_anchor(0, 0, 0, 5, 0, 0, 0, 0));
        pending_anchors.push_back(mk_anchor(3, 4, 7, 0, 0, 0, 0, 0));
        pending_anchors.push_back(mk_anchor(0, 0, 0, 0, 16'h7FFF, 0, 0, 0));
        pending_anchors.push_back(mk_anchor(0, 0, 1, 1, 0, 0, 0, 0));
        pending_anchors.push_back(mk_anchor(1023, 1023, 2047, 2047, 0, 0, 0, 0));
        pending_anchors.push_back(mk_anchor(1023, 0, 2047, 1, 16'h7FFF, 16'h8000, 0, 0));
        pending_anchors.push_back(mk_anchor(0, 1023, 1, 2047, 16'h8000, 16'h7FFF, 0, 0));
        pending_anchors.push_back(mk_anchor(10, 10, 32, 32, 0, 0, 16'h7FFF, 16'h7FFF));
        pending_anchors.push_back(mk_anchor(10, 10, 32, 32, 0, 0, 16'h8000, 16'h8000));
        pending_anchors.push_back(mk_anchor(512, 512, 2047, 2047, 0, 0, 16'h7FFF, 0));
        pending_anchors.push_back(mk_anchor(5, 5, 64, 64, 16'h1000, 16'hF000, 16'h1000,
                                            16'hF000));
        pending_anchors.push_back(mk_anchor(100, 200, 100, 50, 16'h0800, 16'h0800,
                                            16'h2C5C, 16'hD3A4));
        pending_anchors.push_back(mk_anchor(1023, 1023, 2047, 2047, 16'h7FFF, 16'h7FFF,
                                            16'h7FFF, 16'h7FFF));
        pending_anchors.push_back(mk_anchor(0, 0, 2047, 2047, 16'h8000, 16'h8000,
                                            16'h8000, 16'h8000));
        pending_anchors.push_back(mk_anchor(10'h2AA, 10'h155, 11'h555, 11'h2AA, 16'hAAAA,
                                            16'h5555, 16'h0AAA, 16'hF555));
        pending_anchors.push_back(mk_anchor(10'h155, 10'h2AA, 11'h2AA, 11'h555, 16'h5555,
                                            16'hAAAA, 16'hF555, 16'h0AAA));
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_GRID_STRIDE, 16'd1);
                    write_reg(CFG_SCALE_X0, 16'd0);
                    write_reg(CFG_SCALE_Y0, 16'd0);
                    write_reg(CFG_SCALE_WIDTH, 16'd0);
                    write_reg(CFG_SCALE_HEIGHT, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_GRID_STRIDE, 16'd256);
                    write_reg(CFG_SCALE_X0, 16'hFFFF);
                    write_reg(CFG_SCALE_Y0, 16'hFFFF);
                    write_reg(CFG_SCALE_WIDTH, 16'hFFFF);
                    write_reg(CFG_SCALE_HEIGHT, 16'hFFFF);
                end
                2:
                begin
                    // stride of zero and unknown indexes
                    write_reg(CFG_GRID_STRIDE, 16'd0);
                    write_reg(CFG_SCALE_X0, 16'($urandom));
                    write_reg(CFG_SCALE_Y0, 16'($urandom));
                    write_reg(CFG_SCALE_WIDTH, 16'($urandom_range(0, 32768)));
                    write_reg(CFG_SCALE_HEIGHT, 16'($urandom_range(0, 32768)));
                    write_reg(3'd5, 16'($urandom));
                    write_reg(3'd6, 16'($urandom));
                    write_reg(3'd7, 16'($urandom));
                end
                3:
                begin
                    // stride above range, upper data bits dropped
                    write_reg(CFG_GRID_STRIDE, 16'hFFFF);
                    write_reg(CFG_SCALE_X0, 16'($urandom));
                    write_reg(CFG_SCALE_Y0, 16'($urandom));
                    write_reg(CFG_SCALE_WIDTH, 16'($urandom));
                    write_reg(CFG_SCALE_HEIGHT, 16'($urandom));
                end
                default:
                begin
                    write_reg(CFG_GRID_STRIDE, 16'($urandom_range(1, 256)));
                    write_reg(CFG_SCALE_X0, 16'($urandom_range(4096, 32768)));
                    write_reg(CFG_SCALE_Y0, 16'($urandom_range(4096, 32768)));
                    write_reg(CFG_SCALE_WIDTH, 16'($urandom_range(4096, 32768)));
                    write_reg(CFG_SCALE_HEIGHT, 16'($urandom_range(4096, 32768)));
                end
            endcase
            stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            max_gap = (p % 3 == 2) ? 0 : $urandom_range(2, 12);
            for (int i = 0; i < PER_PHASE; i++)
                pending_anchors.push_back(rand_anchor());
            if (p == 1)
            begin
                @(negedge clk);
                hold_req = 1'b1;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("anchor_box_decode test passed");
        else
            $display("anchor_box_decode test failed");
        $finish;
    end

endmodule
